FILE: rtl/pcbm_pkg.sv
// Shared types and constants for the parity-class binned mean block.
`default_nettype none
package pcbm_pkg;

  // Store geometry: one row per bin plus one row of totals
  localparam int NUM_CLASSES = 8;
  localparam int NUM_SLOTS   = NUM_CLASSES * 2;
  localparam int SUM_W       = 48;
  localparam int CNT_W       = 32;
  localparam int SLOT_W      = SUM_W + CNT_W;
  localparam int ROW_W       = NUM_SLOTS * SLOT_W;

  // Serial divider: 48-bit dividend, 32-bit divisor
  localparam int DVD_W     = 48;
  localparam int DVS_W     = 32;
  localparam int DIV_CNT_W = 6;

  // Operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ACC   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_BIN_SCALE   = 2'd0;
  localparam logic [1:0] REG_ACTIVE_BINS = 2'd1;

  localparam logic [23:0] BIN_SCALE_RST   = 24'd4096;
  localparam logic [6:0]  ACTIVE_BINS_RST = 7'd60;

  // Divider handshake toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

FILE: rtl/pcbm_div.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module pcbm_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [pcbm_pkg::DVD_W-1:0]  dividend_i,
  input  wire logic [pcbm_pkg::DVS_W-1:0]  divisor_i,
  output pcbm_pkg::div_stat_t              stat_o,
  output logic      [pcbm_pkg::DVD_W-1:0]  quotient_o
);

  logic                             busy_q, done_q;
  logic [pcbm_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic [pcbm_pkg::DVD_W-1:0]       dq_q, dq_d;
  logic [pcbm_pkg::DVS_W-1:0]       rem_q, rem_d, den_q;
  logic [pcbm_pkg::DVS_W:0]         rem_sh, diff;
  logic                             ge;

  // One shift-subtract step
  always_comb begin
    rem_sh = {rem_q, dq_q[pcbm_pkg::DVD_W-1]};
    diff   = rem_sh - {1'b0, den_q};
    ge     = rem_sh >= {1'b0, den_q};
    rem_d  = ge ? diff[pcbm_pkg::DVS_W-1:0] : rem_sh[pcbm_pkg::DVS_W-1:0];
    dq_d   = {dq_q[pcbm_pkg::DVD_W-2:0], ge};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == pcbm_pkg::DIV_CNT_W'(pcbm_pkg::DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = dq_q;

endmodule
`default_nettype wire

FILE: rtl/pcbm_store.sv
// Bin-row store: one wide synchronous memory with per-row valid bits.
`default_nettype none
module pcbm_store #(
  parameter int ROWS = 65,
  parameter int AW   = 7
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          clr_i,
  input  wire logic                          rd_en_i,
  input  wire logic [AW-1:0]                 rd_addr_i,
  input  wire logic                          wr_en_i,
  input  wire logic [AW-1:0]                 wr_addr_i,
  input  wire logic [pcbm_pkg::ROW_W-1:0]    wr_data_i,
  output logic      [pcbm_pkg::ROW_W-1:0]    rd_data_o
);

  logic [pcbm_pkg::ROW_W-1:0] mem [ROWS];
  logic [ROWS-1:0]            valid_q;
  logic [pcbm_pkg::ROW_W-1:0] rd_q;
  logic                       rd_valid_q;

  // Row valid bits: an invalid row reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // Memory array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule
`default_nettype wire

FILE: rtl/parity_class_binned_mean.sv
// Top level: sequencer, bin calculation and slot update of the binned mean block.
//
// Input channel (in_valid_i/in_ready_o) takes one transaction per operation:
// clear, accumulate a reflection, or query one class of one bin (or totals).
// Only a query yields an output transaction (out_valid_o/out_ready_i).
// One item is worked on at a time; in_ready_o is high when the sequencer idles.
// Steps per item: clear strobes the store clear from decode; a missing or
//   out-of-range reflection returns to idle after decode or the bin check;
//   accumulate computes the bin, runs the 48-step serial divider for
//   intensity over sigma unless sigma is zero, then updates the store;
//   query reads the row, then runs one mean division per nonzero count.
// The store update takes two read-modify-write passes (bin row, then totals row).
// The output register holds a result until taken; a stalled receiver holds a
// finished query in its last state, and new items wait meanwhile.
// Reset restores bin_scale 4096 and active_bins 60 and clears every row of the
// store at once through its row valid bits. Clear works the same way.
// Configuration writes (cfg_valid_i/cfg_ready_o) are always taken.
`default_nettype none
module parity_class_binned_mean #(
  parameter int MAX_BINS = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [23:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic signed [10:0] index_h_i,
  input  wire logic signed [10:0] index_k_i,
  input  wire logic signed [10:0] index_l_i,
  input  wire logic [19:0]        inv_resol_sq_i,
  input  wire logic signed [31:0] intensity_i,
  input  wire logic [31:0]        sigma_i,
  input  wire logic               is_missing_i,
  input  wire logic [6:0]         query_bin_i,
  input  wire logic [2:0]         query_class_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      even_mean_o,
  output logic signed [31:0]      odd_mean_o,
  output logic [31:0]             even_count_o,
  output logic [31:0]             odd_count_o
);

  localparam int ROWS = MAX_BINS + 1;
  localparam int AW   = $clog2(ROWS);
  localparam logic [AW-1:0] TOT_ROW = AW'(MAX_BINS);
  localparam logic [8:0]    MAXB    = 9'(MAX_BINS);

  localparam int SUM_W = pcbm_pkg::SUM_W;
  localparam int CNT_W = pcbm_pkg::CNT_W;
  localparam int ROW_W = pcbm_pkg::ROW_W;

  localparam logic [1:0] OP_CLEAR_C = pcbm_pkg::OP_CLEAR;
  localparam logic [1:0] OP_ACC_C   = pcbm_pkg::OP_ACC;
  localparam logic [1:0] OP_QUERY_C = pcbm_pkg::OP_QUERY;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_DIVR = 4'd3;
  localparam logic [3:0] S_RD1  = 4'd4;
  localparam logic [3:0] S_WB1  = 4'd5;
  localparam logic [3:0] S_RD2  = 4'd6;
  localparam logic [3:0] S_WB2  = 4'd7;
  localparam logic [3:0] S_QLAT = 4'd8;
  localparam logic [3:0] S_QSE  = 4'd9;
  localparam logic [3:0] S_DIVE = 4'd10;
  localparam logic [3:0] S_QSO  = 4'd11;
  localparam logic [3:0] S_DIVO = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  // Saturating 48-bit add of a 32-bit ratio
  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] s, logic [31:0] r);
    logic [SUM_W:0] t;
    t = {s[SUM_W-1], s} + {{(SUM_W-31){r[31]}}, r};
    if (t[SUM_W] != t[SUM_W-1]) begin
      sat_add = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = t[SUM_W-1:0];
    end
  endfunction

  // Signed Q16.16 from magnitude quotient, clamped to 32 bits
  function automatic logic [31:0] sat_q(logic [pcbm_pkg::DVD_W-1:0] q, logic neg);
    logic big;
    big = |q[pcbm_pkg::DVD_W-1:31];
    if (neg) begin
      sat_q = big ? 32'h8000_0000 : (32'd0 - q[31:0]);
    end else begin
      sat_q = (big || (q[30:0] == 31'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
    end
  endfunction

  // Add one ratio to the selected parity slot of every class of a row
  function automatic logic [ROW_W-1:0] row_update(logic [ROW_W-1:0] row,
                                                  logic [7:0] par, logic [31:0] r);
    logic [ROW_W-1:0] res;
    logic [SUM_W-1:0] s;
    logic [CNT_W-1:0] c;
    int               base;
    res = row;
    for (int i = 0; i < pcbm_pkg::NUM_CLASSES; i++) begin
      base = (i * 2 + int'(par[i])) * pcbm_pkg::SLOT_W;
      s = row[base +: SUM_W];
      c = row[base + SUM_W +: CNT_W];
      res[base +: SUM_W] = sat_add(s, r);
      res[base + SUM_W +: CNT_W] = (&c) ? c : c + 1'b1;
    end
    row_update = res;
  endfunction

  logic [3:0]  state_q, state_d;
  logic [23:0] bin_scale_q;
  logic [6:0]  active_bins_q;

  // Captured item
  logic [1:0]  op_q;
  logic [2:0]  par_hkl_q;
  logic [19:0] s_q;
  logic [31:0] inten_q;
  logic [31:0] sigma_q;
  logic        miss_q;
  logic [6:0]  qbin_q;
  logic [2:0]  qcls_q;

  logic [43:0]       prod_q;
  logic [AW-1:0]     row_q;
  logic [31:0]       ratio_q;
  logic [SUM_W-1:0]  sum_e_q, sum_o_q;
  logic [CNT_W-1:0]  cnt_e_q, cnt_o_q;
  logic [31:0]       mean_e_q, mean_o_q;
  logic              out_valid_q;

  // Store and divider connections
  logic              st_clr, st_rd, st_wr;
  logic [AW-1:0]     st_raddr, st_waddr;
  logic [ROW_W-1:0]  st_wdata, st_rdata;
  logic              dv_start;
  logic [pcbm_pkg::DVD_W-1:0] dv_dvd, dv_q;
  logic [pcbm_pkg::DVS_W-1:0] dv_dvs;
  pcbm_pkg::div_stat_t dv_stat;

  logic [15:0] bin;
  logic [8:0]  limit;
  logic [7:0]  par;
  logic [31:0] inten_mag;
  logic [SUM_W-1:0] sum_e_mag, sum_o_mag;
  logic        in_acc;

  assign in_acc      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Bin index, parity classes and operand magnitudes
  always_comb begin
    bin = (prod_q >= 44'h800_0000) ? 16'((prod_q - 44'h800_0000) >> 28) : 16'd0;
    limit = ({2'b0, active_bins_q} > MAXB) ? MAXB : {2'b0, active_bins_q};
    par[0] = par_hkl_q[0];
    par[1] = par_hkl_q[1];
    par[2] = par_hkl_q[2];
    par[3] = par_hkl_q[0] ^ par_hkl_q[1];
    par[4] = par_hkl_q[0] ^ par_hkl_q[2];
    par[5] = par_hkl_q[1] ^ par_hkl_q[2];
    par[6] = par_hkl_q[0] ^ par_hkl_q[1] ^ par_hkl_q[2];
    par[7] = par[3] | par[4] | par[5];
    inten_mag = inten_q[31] ? (32'd0 - inten_q) : inten_q;
    sum_e_mag = sum_e_q[SUM_W-1] ? ({SUM_W{1'b0}} - sum_e_q) : sum_e_q;
    sum_o_mag = sum_o_q[SUM_W-1] ? ({SUM_W{1'b0}} - sum_o_q) : sum_o_q;
  end

  // Sequencer next state and strobes
  always_comb begin
    state_d  = state_q;
    st_clr   = 1'b0;
    st_rd    = 1'b0;
    st_wr    = 1'b0;
    st_raddr = row_q;
    st_waddr = row_q;
    st_wdata = row_update(st_rdata, par, ratio_q);
    dv_start = 1'b0;
    dv_dvd   = {inten_mag, 16'd0};
    dv_dvs   = sigma_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DEC;
      end
      S_DEC: begin
        case (op_q)
          OP_CLEAR_C: begin
            st_clr  = 1'b1;
            state_d = S_IDLE;
          end
          OP_ACC_C: begin
            state_d = miss_q ? S_IDLE : S_CHK;
          end
          OP_QUERY_C: begin
            st_rd    = 1'b1;
            st_raddr = (32'(qbin_q) >= 32'(MAX_BINS)) ? TOT_ROW : AW'(qbin_q);
            state_d  = S_QLAT;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_CHK: begin
        if (bin >= 16'(limit)) begin
          state_d = S_IDLE;
        end else if (sigma_q != 32'd0) begin
          dv_start = 1'b1;
          state_d  = S_DIVR;
        end else begin
          state_d = S_RD1;
        end
      end
      S_DIVR: begin
        if (dv_stat.done) state_d = S_RD1;
      end
      S_RD1: begin
        st_rd   = 1'b1;
        state_d = S_WB1;
      end
      S_WB1: begin
        st_wr   = 1'b1;
        state_d = S_RD2;
      end
      S_RD2: begin
        st_rd    = 1'b1;
        st_raddr = TOT_ROW;
        state_d  = S_WB2;
      end
      S_WB2: begin
        st_wr    = 1'b1;
        st_waddr = TOT_ROW;
        state_d  = S_IDLE;
      end
      S_QLAT: state_d = S_QSE;
      S_QSE: begin
        dv_dvd = sum_e_mag;
        dv_dvs = cnt_e_q;
        if (cnt_e_q != '0) begin
          dv_start = 1'b1;
          state_d  = S_DIVE;
        end else begin
          state_d = S_QSO;
        end
      end
      S_DIVE: begin
        if (dv_stat.done) state_d = S_QSO;
      end
      S_QSO: begin
        dv_dvd = sum_o_mag;
        dv_dvs = cnt_o_q;
        if (cnt_o_q != '0) begin
          dv_start = 1'b1;
          state_d  = S_DIVO;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIVO: begin
        if (dv_stat.done) state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      bin_scale_q   <= pcbm_pkg::BIN_SCALE_RST;
      active_bins_q <= pcbm_pkg::ACTIVE_BINS_RST;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          pcbm_pkg::REG_BIN_SCALE:   bin_scale_q   <= cfg_data_i;
          pcbm_pkg::REG_ACTIVE_BINS: active_bins_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= operation_i;
      par_hkl_q <= {index_l_i[0], index_k_i[0], index_h_i[0]};
      s_q       <= inv_resol_sq_i;
      inten_q   <= intensity_i;
      sigma_q   <= sigma_i;
      miss_q    <= is_missing_i;
      qbin_q    <= query_bin_i;
      qcls_q    <= query_class_i;
    end
    if (state_q == S_DEC) begin
      prod_q <= 44'(s_q) * 44'(bin_scale_q);
    end
    if (state_q == S_CHK) begin
      row_q   <= AW'(bin);
      ratio_q <= 32'd0;
    end
    if (state_q == S_DIVR && dv_stat.done) begin
      ratio_q <= sat_q(dv_q, inten_q[31]);
    end
    if (state_q == S_QLAT) begin
      sum_e_q <= st_rdata[int'({qcls_q, 1'b0}) * pcbm_pkg::SLOT_W +: SUM_W];
      cnt_e_q <= st_rdata[int'({qcls_q, 1'b0}) * pcbm_pkg::SLOT_W + SUM_W +: CNT_W];
      sum_o_q <= st_rdata[int'({qcls_q, 1'b1}) * pcbm_pkg::SLOT_W +: SUM_W];
      cnt_o_q <= st_rdata[int'({qcls_q, 1'b1}) * pcbm_pkg::SLOT_W + SUM_W +: CNT_W];
      mean_e_q <= 32'd0;
      mean_o_q <= 32'd0;
    end
    if (state_q == S_DIVE && dv_stat.done) mean_e_q <= sat_q(dv_q, sum_e_q[SUM_W-1]);
    if (state_q == S_DIVO && dv_stat.done) mean_o_q <= sat_q(dv_q, sum_o_q[SUM_W-1]);
    if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
      even_mean_o  <= mean_e_q;
      odd_mean_o   <= mean_o_q;
      even_count_o <= cnt_e_q;
      odd_count_o  <= cnt_o_q;
    end
  end

  assign out_valid_o = out_valid_q;

  pcbm_store #(
    .ROWS (ROWS),
    .AW   (AW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (st_clr),
    .rd_en_i   (st_rd),
    .rd_addr_i (st_raddr),
    .wr_en_i   (st_wr),
    .wr_addr_i (st_waddr),
    .wr_data_i (st_wdata),
    .rd_data_o (st_rdata)
  );

  pcbm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_dvd),
    .divisor_i  (dv_dvs),
    .stat_o     (dv_stat),
    .quotient_o (dv_q)
  );

  // Store is never read and written in one cycle
  a_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(st_rd && st_wr))
    else $error("store read and write overlap");

  // Every accepted transaction leaves idle
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("accepted transaction not taken up");

  // Divider completes only while a division is awaited
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_stat.done |-> (state_q == S_DIVR || state_q == S_DIVE || state_q == S_DIVO))
    else $error("divider result without waiting state");

  // A new division never starts on a busy divider
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_start |-> !dv_stat.busy)
    else $error("divider restarted while busy");

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the parity-class binned mean block.
module testbench;

  // Operation code that the block ignores
  localparam logic [1:0] OP_SKIP = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic signed [10:0] h, k, l;
    logic [19:0]        s;
    logic signed [31:0] inten;
    logic [31:0]        sigma;
    logic               miss;
    logic [6:0]         qbin;
    logic [2:0]         qcls;
  } refl_t;

  typedef struct packed {
    logic [31:0] even_mean, odd_mean, even_count, odd_count;
  } means_t;

  // Predicts query results and matches them against the block output
  class mean_scoreboard;
    localparam longint SUM_HI = 64'sd140737488355327;
    localparam longint SUM_LO = -SUM_HI - 1;
    longint      bin_sums[64*16];
    int unsigned bin_counts[64*16];
    longint      tot_sums[16];
    int unsigned tot_counts[16];
    logic [23:0] scale;
    logic [6:0]  active;
    means_t      pending_means[$];
    int          errors;

    function new();
      scale  = pcbm_pkg::BIN_SCALE_RST;
      active = pcbm_pkg::ACTIVE_BINS_RST;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (bin_sums[i]) begin
        bin_sums[i] = 0;
        bin_counts[i] = 0;
      end
      foreach (tot_sums[i]) begin
        tot_sums[i] = 0;
        tot_counts[i] = 0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] data);
      if (idx == pcbm_pkg::REG_BIN_SCALE) scale = data;
      else if (idx == pcbm_pkg::REG_ACTIVE_BINS) active = data[6:0];
    endfunction

    // signed quotient toward zero, saturated to Q16.16
    function longint sat_div(longint num, longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = mag / den;
      if (q > 64'sd4294967296) q = 64'sd4294967296;
      if (num < 0) q = -q;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q;
    endfunction

    function void add_slot(ref longint sum, ref int unsigned cnt, input longint r);
      longint t;
      t = sum + r;
      sum = (t > SUM_HI) ? SUM_HI : ((t < SUM_LO) ? SUM_LO : t);
      if (cnt != 32'hFFFF_FFFF) cnt++;
    endfunction

    function void note_item(refl_t it);
      longint prod, bin, lim, r;
      logic [7:0] par;
      int slot;
      means_t m;
      if (it.op == pcbm_pkg::OP_CLEAR) wipe();
      else if (it.op == pcbm_pkg::OP_ACC && !it.miss) begin
        prod = longint'(it.s) * longint'(scale);
        bin = (prod >= (64'sd1 << 27)) ? ((prod - (64'sd1 << 27)) >>> 28) : 0;
        lim = (active > 64) ? 64 : active;
        if (bin < lim) begin
          r = 0;
          if (it.sigma != 0) r = sat_div(longint'(it.inten) * 65536, longint'(it.sigma));
          par[0] = it.h[0];
          par[1] = it.k[0];
          par[2] = it.l[0];
          par[3] = it.h[0] ^ it.k[0];
          par[4] = it.h[0] ^ it.l[0];
          par[5] = it.k[0] ^ it.l[0];
          par[6] = it.h[0] ^ it.k[0] ^ it.l[0];
          par[7] = par[3] | par[4] | par[5];
          for (int c = 0; c < 8; c++) begin
            slot = c * 2 + par[c];
            add_slot(bin_sums[bin*16 + slot], bin_counts[bin*16 + slot], r);
            add_slot(tot_sums[slot], tot_counts[slot], r);
          end
        end
      end else if (it.op == pcbm_pkg::OP_QUERY) begin
        longint sm[2];
        int unsigned cn[2];
        for (int p = 0; p < 2; p++) begin
          slot = it.qcls * 2 + p;
          if (it.qbin < 64) begin
            sm[p] = bin_sums[it.qbin*16 + slot];
            cn[p] = bin_counts[it.qbin*16 + slot];
          end else begin
            sm[p] = tot_sums[slot];
            cn[p] = tot_counts[slot];
          end
        end
        m.even_mean  = cn[0] ? 32'(sat_div(sm[0], longint'(cn[0]))) : 32'd0;
        m.odd_mean   = cn[1] ? 32'(sat_div(sm[1], longint'(cn[1]))) : 32'd0;
        m.even_count = cn[0];
        m.odd_count  = cn[1];
        pending_means.push_back(m);
      end
    endfunction

    function void check_result(means_t got);
      means_t exp_m;
      if (pending_means.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result transaction");
        return;
      end
      exp_m = pending_means.pop_front();
      if (got != exp_m) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: mean/count exp %h %h %0d %0d got %h %h %0d %0d",
                   exp_m.even_mean, exp_m.odd_mean, exp_m.even_count, exp_m.odd_count,
                   got.even_mean, got.odd_mean, got.even_count, got.odd_count);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic [1:0] operation_i = '0;
  logic signed [10:0] index_h_i = '0, index_k_i = '0, index_l_i = '0;
  logic [19:0] inv_resol_sq_i = '0;
  logic signed [31:0] intensity_i = '0;
  logic [31:0] sigma_i = '0;
  logic is_missing_i = 1'b0;
  logic [6:0] query_bin_i = '0;
  logic [2:0] query_class_i = '0;
  logic cfg_ready_o, in_ready_o, out_valid_o;
  logic signed [31:0] even_mean_o, odd_mean_o;
  logic [31:0] even_count_o, odd_count_o;

  mean_scoreboard sb = new();
  bit no_gaps = 1'b0;

  always #5 clk_i = ~clk_i;

  parity_class_binned_mean dut (.*);

  // Drives one input transaction, optionally after a random gap
  task automatic send_item(refl_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation_i <= it.op;
    index_h_i <= it.h;
    index_k_i <= it.k;
    index_l_i <= it.l;
    inv_resol_sq_i <= it.s;
    intensity_i <= it.inten;
    sigma_i <= it.sigma;
    is_missing_i <= it.miss;
    query_bin_i <= it.qbin;
    query_class_i <= it.qcls;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
    @(negedge clk_i);
  endtask

  // Writes a register while the block is idle
  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Holds off until all expected results have arrived, then lets the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_means.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  function automatic refl_t make_item();
    refl_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.op = (pick < 3) ? pcbm_pkg::OP_CLEAR : (pick < 6) ? OP_SKIP
          : (pick < 66) ? pcbm_pkg::OP_ACC : pcbm_pkg::OP_QUERY;
    it.h = 11'($urandom);
    it.k = 11'($urandom);
    it.l = 11'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      it.h = 11'(int'($urandom_range(0, 8)) - 4);
      it.k = 11'(int'($urandom_range(0, 8)) - 4);
      it.l = 11'(int'($urandom_range(0, 8)) - 4);
    end
    it.s = ($urandom_range(0, 3) == 0) ? 20'($urandom_range(0, 1023)) : 20'($urandom);
    it.inten = ($urandom_range(0, 4) == 0) ? 32'($urandom)
             : 32'(int'($urandom_range(0, 200000)) - 100000);
    pick = $urandom_range(0, 99);
    it.sigma = (pick < 15) ? 32'd0 : (pick < 30) ? 32'($urandom)
             : 32'($urandom_range(1, 4096));
    it.miss = ($urandom_range(0, 9) == 0);
    pick = $urandom_range(0, 99);
    it.qbin = (pick < 70) ? 7'($urandom_range(0, 15))
            : (pick < 85) ? 7'($urandom_range(64, 127)) : 7'($urandom);
    it.qcls = 3'($urandom);
    return it;
  endfunction

  // Result side: random stalls per transaction, none in quiet phases
  initial begin
    means_t got;
    int gap;
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.even_mean = even_mean_o;
      got.odd_mean = odd_mean_o;
      got.even_count = even_count_o;
      got.odd_count = odd_count_o;
      sb.check_result(got);
      @(negedge clk_i);
    end
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    refl_t it;
    logic [23:0] scales[6] = '{24'd4096, 24'd16384, 24'd0, 24'hFFFFFF, 24'd16384, 24'd8192};
    logic [6:0]  actives[6] = '{7'd60, 7'd64, 7'd1, 7'd127, 7'd0, 7'd33};
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty store, extremes of indices and ratio, skips, totals, clear
    it = '{op: pcbm_pkg::OP_QUERY, h: '0, k: '0, l: '0, s: '0, inten: '0, sigma: '0,
           miss: 1'b0, qbin: '0, qcls: '0};
    send_item(it);
    it.op = pcbm_pkg::OP_ACC; it.h = 11'(-1024); it.k = 11'(1023); it.l = '0; it.s = '0;
    it.inten = 32'sh7FFF_FFFF; it.sigma = 32'd1;
    send_item(it);
    it.h = 11'(1023); it.k = 11'(-1023); it.l = 11'(-1024); it.s = 20'hFFFFF;
    it.inten = 32'sh8000_0000; it.sigma = 32'hFFFF_FFFF;
    send_item(it);
    it.s = 20'h18000; it.inten = -32'sd12345; it.sigma = 32'd0;
    send_item(it);
    it.s = 20'h28000; it.inten = 32'sh8000_0000; it.sigma = 32'd1; it.miss = 1'b1;
    send_item(it);
    it.miss = 1'b0; it.h = 11'sd1; it.k = 11'sd1; it.l = 11'sd1; it.s = 20'hF0000;
    send_item(it);
    it.op = OP_SKIP;
    send_item(it);
    it.op = pcbm_pkg::OP_QUERY;
    for (int c = 0; c < 8; c++) begin
      it.qcls = 3'(c); it.qbin = (c < 4) ? 7'd0 : 7'd64;
      send_item(it);
    end
    it.qbin = 7'd127; it.qcls = 3'd7; send_item(it);
    it.qbin = 7'd14; send_item(it);
    it.qbin = 7'd63; send_item(it);
    it.op = pcbm_pkg::OP_CLEAR; send_item(it);
    it.op = pcbm_pkg::OP_QUERY; it.qbin = 7'd64; it.qcls = 3'd0; send_item(it);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(pcbm_pkg::REG_BIN_SCALE, scales[ph]);
      write_reg(pcbm_pkg::REG_ACTIVE_BINS, {17'd0, actives[ph]});
      no_gaps = (ph == 2);
      for (int n = 0; n < 150; n++) send_item(make_item());
    end
    drain();

    if (sb.errors == 0 && sb.pending_means.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/pcbm_pkg.sv
rtl/pcbm_div.sv
rtl/pcbm_store.sv
rtl/parity_class_binned_mean.sv
bench/testbench.sv
